// ===== rtl/core/log_block_deframer_unit_defines.svh =====
// Assertion macros used by the deframer checker.
`ifndef LOG_BLOCK_DEFRAMER_UNIT_DEFINES_SVH
`define LOG_BLOCK_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LBD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/lbd_pkg.sv =====
`timescale 1ns / 1ps

package lbd_pkg;

   // Block marker bytes.
   localparam logic [7:0] MARK_RECORD   = 8'h52;
   localparam logic [7:0] MARK_KEYFRAME = 8'h4B;
   localparam logic [7:0] MARK_TRAILER  = 8'h54;

   // Prefix lengths in bytes that follow each marker.
   localparam int REC_PREFIX_LEN = 8 + 4 + 1 + 1 + 1 + 4;
   localparam int KF_PREFIX_LEN  = 8 + 4;
   localparam int TRL_PREFIX_LEN = 4 + 8 + 8 + 8;
   localparam int PREFIX_DEPTH   = TRL_PREFIX_LEN;

   // Count value at which the final prefix byte arrives.
   localparam logic [4:0] REC_PREFIX_LAST = 5'(REC_PREFIX_LEN - 1);
   localparam logic [4:0] KF_PREFIX_LAST  = 5'(KF_PREFIX_LEN - 1);
   localparam logic [4:0] TRL_PREFIX_LAST = 5'(TRL_PREFIX_LEN - 1);

   // Input command codes.
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_SEEK = 1'b1;

   // Result kinds, carried on tuser.
   typedef enum logic [2:0] {
      KIND_RECORD   = 3'd0,
      KIND_PAYLOAD  = 3'd1,
      KIND_KEYFRAME = 3'd2,
      KIND_TRAILER  = 3'd3,
      KIND_ERROR    = 3'd4
   } kind_type;

   // Result data, last field in the lowest bits.
   typedef struct packed {
      logic [63:0]        keyframe_total;
      logic [63:0]        record_total;
      logic [47:0]        block_offset;
      logic [7:0]         payload_byte;
      logic [31:0]        payload_length;
      logic [7:0]         broadcast_byte;
      logic [7:0]         lane;
      logic [7:0]         record_class;
      logic signed [31:0] frame;
      logic [63:0]        wall_ms;
   } rsp_data_type;

endpackage

// ===== rtl/core/log_block_deframer_unit.sv =====
// Channel   Direction  tdata (low bit up)               tuser       tlast
// req_      in         data_byte, seek_offset (56 bits)  command     -
// rsp_      out        wall_ms, frame, record_class,     kind        last
//                      lane, broadcast_byte,
//                      payload_length, payload_byte,
//                      block_offset, record_total,
//                      keyframe_total (336 bits)
// csr_      in         first_block_offset (48 bits), write only
//
// One beat is taken per cycle while the output register is free or being emptied;
// its result, if any, is loaded into the output register in the cycle after. The
// phase update and prefix byte capture are combinational. A stalled result blocks
// the input only while the output register is full and not taken. Reset is
// synchronous; the block needs no clearing pass and takes beats right after reset.
`timescale 1ns / 1ps

module log_block_deframer_unit
   import lbd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // Request channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [55:0]  req_tdata,   // data_byte [7:0], seek_offset [55:8]
   input  logic         req_tuser,   // command
   // Result channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [335:0] rsp_tdata,   // wall_ms, frame, record_class, lane,
                                     // broadcast_byte, payload_length,
                                     // payload_byte, block_offset,
                                     // record_total, keyframe_total
   output logic [2:0]   rsp_tuser,   // kind
   output logic         rsp_tlast,
   // Configuration.
   input  logic         csr_we,
   input  logic [47:0]  csr_wdata
);

   typedef enum logic [2:0] {
      PH_MARKER,
      PH_REC,
      PH_PAYLOAD,
      PH_KF,
      PH_TRL,
      PH_STOP,
      PH_TORN
   } phase_type;

   // Parser state.
   phase_type    phase_ff, phase_in;
   logic [4:0]   prefix_count_ff, prefix_count_in;
   logic [31:0]  payload_remaining_ff, payload_remaining_in;
   logic [47:0]  byte_offset_ff, byte_offset_in;
   logic [47:0]  marker_offset_ff, marker_offset_in;
   logic         untouched_ff, untouched_in;
   logic [7:0]   prefix_ff [PREFIX_DEPTH];

   // Output register.
   logic         rsp_valid_ff;
   kind_type     rsp_kind_ff;
   logic         rsp_last_ff;
   rsp_data_type rsp_data_ff;

   // Result of the current beat.
   logic         res_valid;
   kind_type     res_kind;
   logic         res_last;
   rsp_data_type res_data;

   logic         accept;
   logic         prefix_we;
   logic [7:0]   data_byte;
   logic [47:0]  seek_offset;
   logic [8*PREFIX_DEPTH-1:0] cur_flat;

   assign data_byte   = req_tdata[7:0];
   assign seek_offset = req_tdata[55:8];

   // Take a beat whenever the output register is free or being emptied, never in reset.
   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   // Prefix bytes with the current byte placed at its slot, so a header result can
   // be formed in the cycle its last byte arrives.
   always_comb begin
      for (int i = 0; i < PREFIX_DEPTH; i++) begin
         cur_flat[8*i +: 8] = (prefix_count_ff == 5'(i)) ? data_byte : prefix_ff[i];
      end
   end

   // Phase update and result formation.
   always_comb begin
      phase_in             = phase_ff;
      prefix_count_in      = prefix_count_ff;
      payload_remaining_in = payload_remaining_ff;
      byte_offset_in       = byte_offset_ff;
      marker_offset_in     = marker_offset_ff;
      untouched_in         = untouched_ff && !accept;
      prefix_we            = 1'b0;
      res_valid            = 1'b0;
      res_kind             = KIND_RECORD;
      res_last             = 1'b0;
      res_data             = '0;

      // Before the first beat the start offset follows the register.
      if (csr_we && untouched_ff) begin
         byte_offset_in = csr_wdata;
      end

      if (accept) begin
         if (req_tuser == CMD_SEEK) begin
            byte_offset_in       = seek_offset;
            phase_in             = PH_MARKER;
            prefix_count_in      = '0;
            payload_remaining_in = '0;
         end else begin
            unique case (phase_ff)
               PH_MARKER: begin
                  marker_offset_in = byte_offset_ff;
                  prefix_count_in  = '0;
                  byte_offset_in   = byte_offset_ff + 48'd1;
                  unique case (data_byte)
                     MARK_RECORD:   phase_in = PH_REC;
                     MARK_KEYFRAME: phase_in = PH_KF;
                     MARK_TRAILER:  phase_in = PH_TRL;
                     default: begin
                        // Bad marker: the offset stays on it and parsing halts.
                        phase_in               = PH_TORN;
                        byte_offset_in         = byte_offset_ff;
                        res_valid              = 1'b1;
                        res_kind               = KIND_ERROR;
                        res_last               = 1'b1;
                        res_data.block_offset  = byte_offset_ff;
                     end
                  endcase
               end
               PH_PAYLOAD: begin
                  byte_offset_in        = byte_offset_ff + 48'd1;
                  payload_remaining_in  = payload_remaining_ff - 32'd1;
                  res_valid             = 1'b1;
                  res_kind              = KIND_PAYLOAD;
                  res_data.payload_byte = data_byte;
                  if (payload_remaining_ff == 32'd1) begin
                     res_last = 1'b1;
                     phase_in = PH_MARKER;
                  end
               end
               PH_REC: begin
                  byte_offset_in  = byte_offset_ff + 48'd1;
                  prefix_we       = 1'b1;
                  prefix_count_in = prefix_count_ff + 5'd1;
                  if (prefix_count_ff == REC_PREFIX_LAST) begin
                     prefix_count_in         = '0;
                     payload_remaining_in    = cur_flat[151:120];
                     res_valid               = 1'b1;
                     res_kind                = KIND_RECORD;
                     res_data.wall_ms        = cur_flat[63:0];
                     res_data.frame          = cur_flat[95:64];
                     res_data.record_class   = cur_flat[103:96];
                     res_data.lane           = cur_flat[111:104];
                     res_data.broadcast_byte = cur_flat[119:112];
                     res_data.payload_length = cur_flat[151:120];
                     if (cur_flat[151:120] == 32'd0) begin
                        res_last = 1'b1;
                        phase_in = PH_MARKER;
                     end else begin
                        phase_in = PH_PAYLOAD;
                     end
                  end
               end
               PH_KF: begin
                  byte_offset_in  = byte_offset_ff + 48'd1;
                  prefix_we       = 1'b1;
                  prefix_count_in = prefix_count_ff + 5'd1;
                  if (prefix_count_ff == KF_PREFIX_LAST) begin
                     prefix_count_in       = '0;
                     phase_in              = PH_MARKER;
                     res_valid             = 1'b1;
                     res_kind              = KIND_KEYFRAME;
                     res_last              = 1'b1;
                     res_data.wall_ms      = cur_flat[63:0];
                     res_data.frame        = cur_flat[95:64];
                     res_data.block_offset = marker_offset_ff;
                  end
               end
               PH_TRL: begin
                  byte_offset_in  = byte_offset_ff + 48'd1;
                  prefix_we       = 1'b1;
                  prefix_count_in = prefix_count_ff + 5'd1;
                  if (prefix_count_ff == TRL_PREFIX_LAST) begin
                     prefix_count_in         = '0;
                     phase_in                = PH_STOP;
                     res_valid               = 1'b1;
                     res_kind                = KIND_TRAILER;
                     res_last                = 1'b1;
                     res_data.frame          = cur_flat[31:0];
                     res_data.wall_ms        = cur_flat[95:32];
                     res_data.record_total   = cur_flat[159:96];
                     res_data.keyframe_total = cur_flat[223:160];
                  end
               end
               default: begin
                  // Stopped or torn: bytes are dropped and the offset holds.
               end
            endcase
         end
      end
   end

   // Parser state and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff             <= PH_MARKER;
         prefix_count_ff      <= '0;
         payload_remaining_ff <= '0;
         byte_offset_ff       <= '0;
         marker_offset_ff     <= '0;
         untouched_ff         <= 1'b1;
         rsp_valid_ff         <= 1'b0;
      end else begin
         phase_ff             <= phase_in;
         prefix_count_ff      <= prefix_count_in;
         payload_remaining_ff <= payload_remaining_in;
         byte_offset_ff       <= byte_offset_in;
         marker_offset_ff     <= marker_offset_in;
         untouched_ff         <= untouched_in;
         if (res_valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload and prefix bytes need no reset.
   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_kind_ff <= res_kind;
         rsp_last_ff <= res_last;
         rsp_data_ff <= res_data;
      end
      if (prefix_we) begin
         prefix_ff[prefix_count_ff] <= data_byte;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/core/lbd_checker.sv =====
`timescale 1ns / 1ps
`include "log_block_deframer_unit_defines.svh"

module lbd_checker
   import lbd_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [55:0]  req_tdata,
   input logic         req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [335:0] rsp_tdata,
   input logic [2:0]   rsp_tuser,
   input logic         rsp_tlast,
   input logic         csr_we,
   input logic [47:0]  csr_wdata
);

   // A stalled result beat stays valid.
   `LBD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "result beat dropped while stalled")

   // A stalled result beat keeps its contents.
   `LBD_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "result beat changed while stalled")

   // With the output register empty the input is never blocked.
   `LBD_ASSERT_NOW(a_ready_free, clock, reset, !rsp_tvalid, req_tready, "input blocked with empty output")

   // Keyframe, trailer and framing error each close a block.
   `LBD_ASSERT_NOW(a_last_kinds, clock, reset, rsp_tvalid && (rsp_tuser == KIND_KEYFRAME || rsp_tuser == KIND_TRAILER || rsp_tuser == KIND_ERROR), rsp_tlast, "block-closing result without tlast")

   // Only defined result kinds appear.
   `LBD_ASSERT_NOW(a_kind_range, clock, reset, rsp_tvalid, rsp_tuser <= KIND_ERROR, "undefined result kind")

endmodule

bind log_block_deframer_unit lbd_checker u_lbd_checker (.*);

// ===== sim/log_block_deframer_unit_tb.sv =====
`timescale 1ns / 1ps

module log_block_deframer_unit_tb;
   import lbd_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_BEATS  = 150;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE_TICKS = 4;
   localparam logic [47:0] OFFSET_MAX = 48'hFFFF_FFFF_FFFF;

   // Parser states of the predictor.
   typedef enum logic [2:0] {
      ST_MARKER, ST_REC, ST_PAYLOAD, ST_KF, ST_TRL, ST_STOP, ST_TORN
   } parse_state_type;

   // One beat on the request channel.
   typedef struct {
      logic        cmd;
      logic [7:0]  dbyte;
      logic [47:0] ofs;
   } req_beat_type;

   // One result beat as the block should deliver it.
   typedef struct {
      kind_type     kind;
      rsp_data_type fields;
      logic         is_last;
   } deframed_type;

   // Directed row; the typed columns hold a result read straight off the framing rules.
   typedef struct {
      logic        cmd;
      logic [7:0]  dbyte;
      logic [47:0] ofs;
      bit          typed;
      kind_type    kind;
      logic [63:0] wall;
      logic [31:0] frame;
      logic [47:0] bofs;
   } script_row_type;

   logic         clock;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [55:0]  req_tdata  = '0;  // data_byte [7:0], seek_offset [55:8]
   logic         req_tuser  = 1'b0; // command
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [335:0] rsp_tdata;        // wall_ms, frame, record_class, lane, broadcast_byte,
                                   // payload_length, payload_byte, block_offset,
                                   // record_total, keyframe_total
   logic [2:0]   rsp_tuser;        // kind
   logic         rsp_tlast;
   logic         csr_we     = 1'b0;
   logic [47:0]  csr_wdata  = '0;

   // Predictor state.
   parse_state_type pstate      = ST_MARKER;
   logic [4:0]      prefix_cnt  = '0;
   logic [7:0]      prefix_buf [28];
   logic [31:0]     payload_left = '0;
   logic [47:0]     cur_offset  = '0;
   logic [47:0]     marker_pos  = '0;
   bit              pristine    = 1'b1;

   deframed_type    expected_q [$];
   script_row_type  directed_rows [$];
   req_beat_type    blk [$];

   int snd_idle_pct  = 0;
   int rcv_stall_pct = 0;
   bit hold_request  = 1'b0;
   int stall_left    = 0;
   int cycle_count   = 0;
   int mismatch_count = 0;
   int driven_beats  = 0;
   int result_beats  = 0;
   int kind_seen [5] = '{default: 0};

   log_block_deframer_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Queue helpers: expected results, directed rows and the beats of one block.
   function automatic void expect_result(input deframed_type r);
      expected_q.insert(expected_q.size(), r);
   endfunction

   function automatic void add_row(input script_row_type r);
      directed_rows.insert(directed_rows.size(), r);
   endfunction

   function automatic void add_beat(input req_beat_type bt);
      blk.insert(blk.size(), bt);
   endfunction

   // Little-endian read of captured prefix bytes.
   function automatic logic [63:0] prefix_le(input int at, input int n);
      logic [63:0] v;
      v = '0;
      for (int i = 0; i < n; i++) v |= 64'(prefix_buf[at + i]) << (8 * i);
      return v;
   endfunction

   // Advances the parser by one accepted beat and works out the result it causes.
   task automatic deframe_beat(input req_beat_type bt, output bit produced, output bit ignored,
         output deframed_type res);
      res = '{kind: KIND_RECORD, fields: '0, is_last: 1'b0};
      produced = 1'b0;
      ignored  = 1'b0;
      pristine = 1'b0;
      if (bt.cmd == CMD_SEEK) begin
         cur_offset   = bt.ofs;
         pstate       = ST_MARKER;
         prefix_cnt   = '0;
         payload_left = '0;
      end else if (pstate == ST_STOP || pstate == ST_TORN) begin
         ignored = 1'b1;
      end else if (pstate == ST_MARKER) begin
         marker_pos = cur_offset;
         prefix_cnt = '0;
         case (bt.dbyte)
            MARK_RECORD:   pstate = ST_REC;
            MARK_KEYFRAME: pstate = ST_KF;
            MARK_TRAILER:  pstate = ST_TRL;
            default: begin
               // A bad marker latches the torn state and keeps the offset on it.
               pstate = ST_TORN;
               res.kind = KIND_ERROR;
               res.fields.block_offset = cur_offset;
               res.is_last = 1'b1;
               produced = 1'b1;
            end
         endcase
         if (pstate != ST_TORN) cur_offset++;
      end else if (pstate == ST_PAYLOAD) begin
         cur_offset++;
         payload_left--;
         res.kind = KIND_PAYLOAD;
         res.fields.payload_byte = bt.dbyte;
         produced = 1'b1;
         if (payload_left == 0) begin
            res.is_last = 1'b1;
            pstate = ST_MARKER;
         end
      end else begin
         // Prefix capture for records, keyframes and the trailer.
         cur_offset++;
         if (prefix_cnt < 28) prefix_buf[prefix_cnt] = bt.dbyte;
         prefix_cnt++;
         if (pstate == ST_REC && prefix_cnt == REC_PREFIX_LEN) begin
            prefix_cnt = '0;
            res.kind = KIND_RECORD;
            res.fields.wall_ms        = prefix_le(0, 8);
            res.fields.frame          = 32'(prefix_le(8, 4));
            res.fields.record_class   = prefix_buf[12];
            res.fields.lane           = prefix_buf[13];
            res.fields.broadcast_byte = prefix_buf[14];
            payload_left              = 32'(prefix_le(15, 4));
            res.fields.payload_length = payload_left;
            res.is_last = (payload_left == 0);
            pstate = (payload_left == 0) ? ST_MARKER : ST_PAYLOAD;
            produced = 1'b1;
         end else if (pstate == ST_KF && prefix_cnt == KF_PREFIX_LEN) begin
            prefix_cnt = '0;
            res.kind = KIND_KEYFRAME;
            res.fields.wall_ms      = prefix_le(0, 8);
            res.fields.frame        = 32'(prefix_le(8, 4));
            res.fields.block_offset = marker_pos;
            res.is_last = 1'b1;
            pstate = ST_MARKER;
            produced = 1'b1;
         end else if (pstate == ST_TRL && prefix_cnt == TRL_PREFIX_LEN) begin
            prefix_cnt = '0;
            res.kind = KIND_TRAILER;
            res.fields.frame          = 32'(prefix_le(0, 4));
            res.fields.wall_ms        = prefix_le(4, 8);
            res.fields.record_total   = prefix_le(12, 8);
            res.fields.keyframe_total = prefix_le(20, 8);
            res.is_last = 1'b1;
            pstate = ST_STOP;
            produced = 1'b1;
         end
      end
   endtask

   function automatic logic [47:0] random_offset();
      if ($urandom_range(3) == 0) return OFFSET_MAX - 48'($urandom_range(0, 40));
      return {16'($urandom), 32'($urandom)};
   endfunction

   function automatic req_beat_type byte_beat(input logic [7:0] b);
      return req_beat_type'{CMD_BYTE, b, random_offset()};
   endfunction

   function automatic req_beat_type seek_beat();
      return req_beat_type'{CMD_SEEK, 8'($urandom), random_offset()};
   endfunction

   // Offers one beat with random sender gaps, then predicts on acceptance.
   task automatic offer_beat(input req_beat_type bt, input bit use_typed,
         input deframed_type typed_res);
      bit produced;
      bit ignored;
      deframed_type res;
      while ($urandom_range(99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= bt.cmd;
      req_tdata  <= {bt.ofs, bt.dbyte};
      do @(posedge clock); while (!req_tready);
      deframe_beat(bt, produced, ignored, res);
      if (!ignored) driven_beats++;
      if (use_typed) expect_result(typed_res);
      else if (produced) expect_result(res);
   endtask

   task automatic write_first_offset(input logic [47:0] v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      if (pristine) cur_offset = v;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Pauses the sender until every expected result has come, then waits the settle ticks.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   function automatic void check_field(input string name, input logic [63:0] want,
         input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h, actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic check_result();
      deframed_type exp;
      rsp_data_type got;
      got = rsp_data_type'(rsp_tdata);
      result_beats++;
      if (rsp_tuser < 5) kind_seen[rsp_tuser]++;
      if (expected_q.size() == 0) begin
         $display("%0t: result beat with nothing expected, expected none, actual kind %0d",
            $time, rsp_tuser);
         mismatch_count++;
      end else begin
         exp = expected_q.pop_front();
         check_field("kind", 64'(exp.kind), 64'(rsp_tuser));
         check_field("wall_ms", exp.fields.wall_ms, got.wall_ms);
         check_field("frame", {32'h0, exp.fields.frame}, {32'h0, got.frame});
         check_field("record_class", 64'(exp.fields.record_class), 64'(got.record_class));
         check_field("lane", 64'(exp.fields.lane), 64'(got.lane));
         check_field("broadcast_byte", 64'(exp.fields.broadcast_byte),
            64'(got.broadcast_byte));
         check_field("payload_length", 64'(exp.fields.payload_length),
            64'(got.payload_length));
         check_field("payload_byte", 64'(exp.fields.payload_byte), 64'(got.payload_byte));
         check_field("block_offset", 64'(exp.fields.block_offset), 64'(got.block_offset));
         check_field("record_total", exp.fields.record_total, got.record_total);
         check_field("keyframe_total", exp.fields.keyframe_total, got.keyframe_total);
         check_field("last", 64'(exp.is_last), 64'(rsp_tlast));
      end
   endtask

   // Result side: check each taken beat, then pick the next ready value.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_result();
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         stall_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rcv_stall_pct);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      script_row_type row;
      deframed_type   typed_res;
      deframed_type   no_res;
      logic [31:0]    len;
      logic [7:0]     b;
      logic [47:0]    cfg;
      int             kind_sel;
      int             cut;
      int             pcount;
      int             target;
      bit             trunc;

      no_res = '{kind: KIND_RECORD, fields: '0, is_last: 1'b0};
      foreach (prefix_buf[i]) prefix_buf[i] = '0;

      // Directed table: offsets at the wrap point, field extremes, torn state, seeks.
      add_row(script_row_type'{CMD_BYTE, 8'h00, 48'h0, 1'b1, KIND_ERROR,
         64'h0, 32'h0, OFFSET_MAX});
      add_row(script_row_type'{CMD_BYTE, MARK_RECORD, 48'h0, 1'b0, KIND_RECORD,
         '0, '0, '0});
      add_row(script_row_type'{CMD_SEEK, 8'hFF, 48'hFFFF_FFFF_FFFE, 1'b0,
         KIND_RECORD, '0, '0, '0});
      add_row(script_row_type'{CMD_BYTE, MARK_KEYFRAME, 48'h0, 1'b0,
         KIND_RECORD, '0, '0, '0});
      for (int i = 0; i < 8; i++)
         add_row(script_row_type'{CMD_BYTE, 8'hFF, OFFSET_MAX, 1'b0,
            KIND_RECORD, '0, '0, '0});
      add_row(script_row_type'{CMD_BYTE, 8'h00, 48'h0, 1'b0, KIND_RECORD,
         '0, '0, '0});
      add_row(script_row_type'{CMD_BYTE, 8'h00, 48'h0, 1'b0, KIND_RECORD,
         '0, '0, '0});
      add_row(script_row_type'{CMD_BYTE, 8'h00, 48'h0, 1'b0, KIND_RECORD,
         '0, '0, '0});
      add_row(script_row_type'{CMD_BYTE, 8'h80, 48'h0, 1'b1, KIND_KEYFRAME,
         64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000, 48'hFFFF_FFFF_FFFE});
      add_row(script_row_type'{CMD_BYTE, MARK_RECORD, 48'h0, 1'b0,
         KIND_RECORD, '0, '0, '0});
      add_row(script_row_type'{CMD_BYTE, 8'h01, 48'h0, 1'b0, KIND_RECORD,
         '0, '0, '0});
      add_row(script_row_type'{CMD_SEEK, 8'h00, 48'h0, 1'b0, KIND_RECORD,
         '0, '0, '0});
      add_row(script_row_type'{CMD_BYTE, 8'hFF, 48'h0, 1'b1, KIND_ERROR,
         64'h0, 32'h0, 48'h0});
      add_row(script_row_type'{CMD_BYTE, MARK_KEYFRAME, 48'h0, 1'b0,
         KIND_RECORD, '0, '0, '0});
      add_row(script_row_type'{CMD_SEEK, 8'h5A, 48'h8000_0000_0001, 1'b0,
         KIND_RECORD, '0, '0, '0});

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Two writes before the first beat: the second one sets the start offset.
      write_first_offset(48'h0);
      write_first_offset(OFFSET_MAX);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         typed_res = '{kind: row.kind, fields: '0, is_last: 1'b1};
         typed_res.fields.wall_ms      = row.wall;
         typed_res.fields.frame        = row.frame;
         typed_res.fields.block_offset = row.bofs;
         offer_beat(req_beat_type'{row.cmd, row.dbyte, row.ofs}, row.typed, typed_res);
      end
      wait_for_results();

      // Random phases, each with a register write and one of four idling mixes.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
            1: begin snd_idle_pct = 75; rcv_stall_pct = 0;  end
            2: begin snd_idle_pct = 0;  rcv_stall_pct = 75; end
            default: begin snd_idle_pct = 21; rcv_stall_pct = 21; end
         endcase
         case (ph)
            0: cfg = 48'h0;
            1: cfg = OFFSET_MAX;
            default: cfg = random_offset();
         endcase
         write_first_offset(cfg);
         if (ph == 4) hold_request = 1'b1;
         target = driven_beats + PHASE_BEATS;
         offer_beat(seek_beat(), 1'b0, no_res);

         while (driven_beats < target) begin
            blk.delete();
            kind_sel = $urandom_range(99);
            trunc = ($urandom_range(99) < 10);
            if (kind_sel < 55) begin
               // Record: marker, 15 header bytes, little-endian length, payload.
               if (trunc) len = $urandom;
               else if ($urandom_range(9) == 0) len = $urandom_range(20, 40);
               else len = $urandom_range(0, 5);
               add_beat(byte_beat(MARK_RECORD));
               repeat (15) add_beat(byte_beat(8'($urandom)));
               for (int i = 0; i < 4; i++) add_beat(byte_beat(len[8*i +: 8]));
               pcount = (len > 40) ? 12 : int'(len);
               repeat (pcount) add_beat(byte_beat(8'($urandom)));
            end else if (kind_sel < 75) begin
               add_beat(byte_beat(MARK_KEYFRAME));
               repeat (KF_PREFIX_LEN) add_beat(byte_beat(8'($urandom)));
            end else if (kind_sel < 80) begin
               // Trailer; bytes after it are dropped until a seek.
               add_beat(byte_beat(MARK_TRAILER));
               repeat (TRL_PREFIX_LEN) add_beat(byte_beat(8'($urandom)));
               if (!trunc) repeat ($urandom_range(0, 3)) add_beat(byte_beat(8'($urandom)));
               add_beat(seek_beat());
            end else if (kind_sel < 86) begin
               do b = 8'($urandom);
               while (b == MARK_RECORD || b == MARK_KEYFRAME || b == MARK_TRAILER);
               add_beat(byte_beat(b));
               repeat ($urandom_range(0, 2)) add_beat(byte_beat(8'($urandom)));
               add_beat(seek_beat());
               trunc = 1'b0;
            end else begin
               add_beat(seek_beat());
               trunc = 1'b0;
            end
            // A cut block is abandoned by a seek.
            if (trunc && blk.size() > 1) begin
               cut = $urandom_range(1, blk.size() - 1);
               blk = blk[0:cut-1];
               add_beat(seek_beat());
            end
            foreach (blk[i]) offer_beat(blk[i], 1'b0, no_res);
         end
         wait_for_results();
      end

      $display("Covered %0d input beats and %0d result beats: %0d record headers, %0d payload",
         driven_beats, result_beats, kind_seen[0], kind_seen[1]);
      $display("bytes, %0d keyframes, %0d trailers, %0d framing errors, with seeks and wrap.",
         kind_seen[2], kind_seen[3], kind_seen[4]);
      if (mismatch_count == 0 && expected_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
